// ===== src/radio_frame_deframer_macros.svh =====
// ---------------------------------------------------------------------------
// radio_frame_deframer assertion macros
// Shared concurrent assertion forms. The using module provides clock and reset.
// ---------------------------------------------------------------------------
`ifndef RADIO_FRAME_DEFRAMER_MACROS_SVH
`define RADIO_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RFD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define RFD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/rfd_pkg.sv =====
// ---------------------------------------------------------------------------
// rfd_pkg
// Types and fixed constants shared by the receive frame deframer modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfd_pkg;

   // result kinds
   typedef enum logic [1:0] {
      KIND_IQ        = 2'd0,
      KIND_MIC       = 2'd1,
      KIND_CONTROL   = 2'd2,
      KIND_FRAME_END = 2'd3
   } kind_type;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      REG_ACTIVE_RECEIVERS = 2'd0,
      REG_RECEIVER_RATE    = 2'd1,
      REG_MIC_INCREMENT    = 2'd2,
      REG_UNUSED           = 2'd3
   } reg_index_type;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic [2:0]  ACTIVE_RECEIVERS_RESET = 3'd0;
   localparam logic [18:0] RECEIVER_RATE_RESET    = 19'd192000;
   localparam logic [18:0] MIC_INCREMENT_RESET    = 19'd48000;

   // frame header layout
   localparam logic [7:0] SYNC_BYTE    = 8'h7F;
   localparam int         SYNC_LEN     = 3;
   localparam int         COMMAND_POS  = 3;
   localparam int         HEADER_BYTES = 8;

   // slot positions inside a sample group
   localparam logic [2:0] GP_I_LAST  = 3'd2;
   localparam logic [2:0] GP_Q_LAST  = 3'd5;
   localparam logic [2:0] GP_MIC_HI  = 3'd6;

   localparam int BYTES_PER_RECEIVER = 6;
   localparam int MIC_BYTES          = 2;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [2:0]  active_receivers;
      logic [18:0] receiver_rate;
      logic [18:0] mic_increment;
   } config_type;

   typedef struct packed {
      kind_type           kind;
      logic [1:0]         receiver;
      logic signed [23:0] i_sample;
      logic signed [23:0] q_sample;
      logic signed [15:0] mic_sample;
      logic [4:0]         control_address;
      logic [31:0]        control_word;
      logic [2:0]         status_bits;
      logic [5:0]         sample_count;
      logic               sync_ok;
      logic               last;
   } result_type;

   // up to two results written per byte
   typedef struct packed {
      logic [1:0] count;
      result_type slot0;
      result_type slot1;
   } push_type;

endpackage

// ===== src/rfd_csr.sv =====
// ---------------------------------------------------------------------------
// rfd_csr
// Configuration registers behind an apb-style write/read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rfd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rfd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rfd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output rfd_pkg::config_type              cfg
);
   import rfd_pkg::*;

   logic [2:0]    active_receivers_ff;
   logic [18:0]   receiver_rate_ff;
   logic [18:0]   mic_increment_ff;
   logic          write_en;
   reg_index_type reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = reg_index_type'(csr_paddr[3:2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         active_receivers_ff <= ACTIVE_RECEIVERS_RESET;
         receiver_rate_ff    <= RECEIVER_RATE_RESET;
         mic_increment_ff    <= MIC_INCREMENT_RESET;
      end else if (write_en) begin
         unique case (reg_index)
            REG_ACTIVE_RECEIVERS: active_receivers_ff <= csr_pwdata[2:0];
            REG_RECEIVER_RATE:    receiver_rate_ff    <= csr_pwdata[18:0];
            REG_MIC_INCREMENT:    mic_increment_ff    <= csr_pwdata[18:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_index)
         REG_ACTIVE_RECEIVERS: csr_prdata = {29'd0, active_receivers_ff};
         REG_RECEIVER_RATE:    csr_prdata = {13'd0, receiver_rate_ff};
         REG_MIC_INCREMENT:    csr_prdata = {13'd0, mic_increment_ff};
         default:              csr_prdata = '0;
      endcase
   end

   assign cfg.active_receivers = active_receivers_ff;
   assign cfg.receiver_rate    = receiver_rate_ff;
   assign cfg.mic_increment    = mic_increment_ff;

endmodule

// ===== src/rfd_parser.sv =====
// ---------------------------------------------------------------------------
// rfd_parser
// Per-byte frame parser: sync check, control word capture, sample groups,
// mic decimator and frame-end report, all updated for each accepted byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radio_frame_deframer_macros.svh"

module rfd_parser #(
   parameter int PAYLOAD_BYTES = 504,
   parameter int MAX_RECEIVERS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                frame_start,
   input  rfd_pkg::config_type cfg,
   output rfd_pkg::push_type   push
);
   import rfd_pkg::*;

   localparam int POS_W = $clog2(PAYLOAD_BYTES + HEADER_BYTES);
   localparam int PL_W  = $clog2(PAYLOAD_BYTES + 1);
   localparam int RX_W  = (MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1;
   localparam int CMP_W = (PL_W > 6) ? PL_W : 6;

   localparam logic [POS_W-1:0] LAST_POS    = POS_W'(HEADER_BYTES + PAYLOAD_BYTES - 1);
   localparam logic [POS_W-1:0] POS_SYNC    = POS_W'(SYNC_LEN);
   localparam logic [POS_W-1:0] POS_COMMAND = POS_W'(COMMAND_POS);
   localparam logic [POS_W-1:0] POS_HEADER  = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0] POS_CTL_END = POS_W'(HEADER_BYTES - 1);
   localparam logic [PL_W-1:0]  PL_FULL     = PL_W'(PAYLOAD_BYTES);
   localparam logic [3:0]       MAX_RX      = 4'(MAX_RECEIVERS);

   // frame state
   logic [POS_W-1:0] pos_ff,  pos_in,  pos_cur;
   logic             sync_ff, sync_in, sync_cur;
   logic [2:0]       gp_ff,   gp_in,   gp_cur;
   logic [RX_W-1:0]  rx_ff,   rx_in,   rx_cur;
   logic [PL_W-1:0]  pl_ff,   pl_in,   pl_cur;
   logic [5:0]       gc_ff,   gc_in,   gc_cur;
   logic [19:0]      acc_ff,  acc_in;
   // data holding registers
   logic [7:0]       cmd_ff,  cmd_in;
   logic [31:0]      ctl_ff,  ctl_in;
   logic [23:0]      iph_ff,  iph_in;
   logic [23:0]      ss_ff,   ss_in;
   logic [7:0]       mic_hi_ff, mic_hi_in;

   logic [3:0]       num_rx;
   logic [5:0]       group_size;
   logic [19:0]      acc_sum;
   logic             res_a_valid;
   logic             frame_end;
   result_type       res_a;
   result_type       res_b;

   // receivers per group, saturated, and group length in bytes
   always_comb begin
      if (cfg.active_receivers == 3'd0) begin
         num_rx = 4'd1;
      end else if ({1'b0, cfg.active_receivers} > MAX_RX) begin
         num_rx = MAX_RX;
      end else begin
         num_rx = {1'b0, cfg.active_receivers};
      end
      group_size = 6'(num_rx) * 6'(BYTES_PER_RECEIVER) + 6'(MIC_BYTES);
   end

   // a frame start restarts the frame counters before this byte
   always_comb begin
      pos_cur  = frame_start ? '0 : pos_ff;
      sync_cur = frame_start ? 1'b1 : sync_ff;
      gp_cur   = frame_start ? '0 : gp_ff;
      rx_cur   = frame_start ? '0 : rx_ff;
      pl_cur   = frame_start ? PL_FULL : pl_ff;
      gc_cur   = frame_start ? '0 : gc_ff;
   end

   assign acc_sum = acc_ff + {1'b0, cfg.mic_increment};

   // byte parse
   always_comb begin
      pos_in      = pos_cur;
      sync_in     = sync_cur;
      gp_in       = gp_cur;
      rx_in       = rx_cur;
      pl_in       = pl_cur;
      gc_in       = gc_cur;
      acc_in      = acc_ff;
      cmd_in      = cmd_ff;
      ctl_in      = ctl_ff;
      iph_in      = iph_ff;
      ss_in       = ss_ff;
      mic_hi_in   = mic_hi_ff;
      res_a_valid = 1'b0;
      res_a       = '0;
      res_b       = '0;
      frame_end   = 1'b0;

      priority if (pos_cur < POS_SYNC) begin
         if (data_byte != SYNC_BYTE) begin
            sync_in = 1'b0;
         end
      end else if (pos_cur == POS_COMMAND) begin
         cmd_in = data_byte;
      end else if (pos_cur < POS_HEADER) begin
         ctl_in = {ctl_ff[23:0], data_byte};
         if (pos_cur == POS_CTL_END && sync_cur) begin
            res_a_valid           = 1'b1;
            res_a.kind            = KIND_CONTROL;
            res_a.control_address = cmd_ff[7:3];
            res_a.control_word    = ctl_in;
            res_a.status_bits     = cmd_ff[2:0];
         end
      end else if (sync_cur && pl_cur != '0) begin
         priority if (gp_cur == '0 && rx_cur == '0
                      && CMP_W'(pl_cur) < CMP_W'(group_size)) begin
            // tail too short for a whole group
            pl_in = '0;
         end else if (gp_cur <= GP_Q_LAST) begin
            pl_in = pl_cur - PL_W'(1);
            ss_in = {ss_ff[15:0], data_byte};
            if (gp_cur == GP_I_LAST) begin
               iph_in = ss_in;
            end
            if (gp_cur == GP_Q_LAST) begin
               if (cfg.active_receivers != 3'd0) begin
                  res_a_valid    = 1'b1;
                  res_a.kind     = KIND_IQ;
                  res_a.receiver = 2'(rx_cur);
                  res_a.i_sample = iph_ff;
                  res_a.q_sample = ss_in;
               end
               if (4'(rx_cur) + 4'd1 < num_rx) begin
                  rx_in = rx_cur + RX_W'(1);
                  gp_in = '0;
               end else begin
                  gp_in = GP_MIC_HI;
               end
            end else begin
               gp_in = gp_cur + 3'd1;
            end
         end else if (gp_cur == GP_MIC_HI) begin
            pl_in     = pl_cur - PL_W'(1);
            mic_hi_in = data_byte;
            gp_in     = gp_cur + 3'd1;
         end else begin
            // mic low byte closes the group
            pl_in = pl_cur - PL_W'(1);
            if (acc_sum >= {1'b0, cfg.receiver_rate}) begin
               acc_in           = '0;
               res_a_valid      = 1'b1;
               res_a.kind       = KIND_MIC;
               res_a.mic_sample = {mic_hi_ff, data_byte};
            end else begin
               acc_in = acc_sum;
            end
            gp_in = '0;
            rx_in = '0;
            gc_in = gc_cur + 6'd1;
         end
      end else begin
         // header done and nothing left to parse
      end

      // frame end report and restart
      if (pos_cur >= LAST_POS) begin
         frame_end          = 1'b1;
         res_b.kind         = KIND_FRAME_END;
         res_b.sample_count = sync_in ? gc_in : 6'd0;
         res_b.sync_ok      = sync_in;
         res_b.last         = 1'b1;
         pos_in             = '0;
         sync_in            = 1'b1;
         gp_in              = '0;
         rx_in              = '0;
         pl_in              = PL_FULL;
         gc_in              = '0;
      end else begin
         pos_in = pos_cur + POS_W'(1);
      end
      res_a.last = !frame_end;
   end

   // results handed to the queue
   always_comb begin
      push.count = accept ? (2'(res_a_valid) + 2'(frame_end)) : 2'd0;
      push.slot0 = res_a_valid ? res_a : res_b;
      push.slot1 = res_b;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         sync_ff <= 1'b1;
         gp_ff   <= '0;
         rx_ff   <= '0;
         pl_ff   <= PL_FULL;
         gc_ff   <= '0;
         acc_ff  <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         sync_ff <= sync_in;
         gp_ff   <= gp_in;
         rx_ff   <= rx_in;
         pl_ff   <= pl_in;
         gc_ff   <= gc_in;
         acc_ff  <= acc_in;
      end
   end

   // data holding registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= cmd_in;
         ctl_ff    <= ctl_in;
         iph_ff    <= iph_in;
         ss_ff     <= ss_in;
         mic_hi_ff <= mic_hi_in;
      end
   end

   // checks
   `RFD_ASSERT_IMP(a_pair_ends_frame, push.count == 2'd2,
      push.slot1.kind == KIND_FRAME_END && push.slot0.kind != KIND_CONTROL,
      "second result of a byte is not a frame end")
   `RFD_ASSERT_NEXT(a_mic_clears_acc, push.count != 2'd0 && push.slot0.kind == KIND_MIC,
      acc_ff == '0, "mic decimator not cleared after a mic sample")
   `RFD_ASSERT_NEXT(a_frame_end_restarts, push.count != 2'd0 && frame_end,
      pos_ff == '0 && gc_ff == '0 && pl_ff == PL_FULL, "frame counters not restarted")
   `RFD_ASSERT_IMP(a_pos_in_frame, 1'b1, pos_ff <= LAST_POS,
      "byte position beyond frame length")

endmodule

// ===== src/rfd_result_queue.sv =====
// ---------------------------------------------------------------------------
// rfd_result_queue
// Four-entry result queue: takes up to two results per cycle and
// delivers one per transaction on the result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radio_frame_deframer_macros.svh"

module rfd_result_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  rfd_pkg::push_type    push,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rfd_pkg::result_type  head
);
   import rfd_pkg::*;

   result_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff,  count_in;
   logic [QPTR_W-1:0] wr_next;
   logic              pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid & rsp_ready;
   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign head      = entry_ff[rd_ptr_ff];
   assign wr_next   = wr_ptr_ff + QPTR_W'(1);

   // pointer and fill updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry writes
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.slot1;
      end
   end

   // checks
   `RFD_ASSERT_IMP(a_fill_bound, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH),
      "result queue overfilled")
   `RFD_ASSERT_IMP(a_push_room, push.count != 2'd0, room,
      "results pushed without room")
   `RFD_ASSERT_IMP(a_pair_last, push.count == 2'd2, !push.slot0.last && push.slot1.last,
      "last flag wrong on a result pair")

endmodule

// ===== src/radio_frame_deframer.sv =====
// ---------------------------------------------------------------------------
// radio_frame_deframer
// Byte-serial receive frame parser: sync check, control word, IQ samples,
// decimated mic samples and a frame-end report per 512-byte frame.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                    contents
//  req_      in         req_valid / req_ready        data_byte, frame_start
//  rsp_      out        rsp_valid / rsp_ready        one result per transaction
//  csr_      in/out     psel, penable, pwrite        3 registers at 0x0, 0x4, 0x8
//
//  One byte is accepted per cycle while the queue has room; its results enter
//  the queue at that edge and rsp_valid rises in the next cycle.
//  A byte yields at most two results (a sample or control word plus a frame
//  end), so the output side may need two transactions for such a byte.
//  req_ready comes from the queue fill level (at most two entries held).
//  Reset is synchronous: counters restart, registers take their reset
//  values and the queue empties; no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module radio_frame_deframer #(
   parameter int PAYLOAD_BYTES = 504,
   parameter int MAX_RECEIVERS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_frame_start,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_kind,
   output logic [1:0]                      rsp_receiver,
   output logic signed [23:0]              rsp_i_sample,
   output logic signed [23:0]              rsp_q_sample,
   output logic signed [15:0]              rsp_mic_sample,
   output logic [4:0]                      rsp_control_address,
   output logic [31:0]                     rsp_control_word,
   output logic [2:0]                      rsp_status_bits,
   output logic [5:0]                      rsp_sample_count,
   output logic                            rsp_sync_ok,
   output logic                            rsp_last,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rfd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rfd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rfd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import rfd_pkg::*;

   config_type cfg;
   push_type   push;
   result_type head;
   logic       accept;

   assign accept = req_valid & req_ready;

   // configuration registers
   rfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // byte parser
   rfd_parser #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .MAX_RECEIVERS (MAX_RECEIVERS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .frame_start (req_frame_start),
      .cfg         (cfg),
      .push        (push)
   );

   // result queue
   rfd_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   // result fields
   assign rsp_kind            = head.kind;
   assign rsp_receiver        = head.receiver;
   assign rsp_i_sample        = head.i_sample;
   assign rsp_q_sample        = head.q_sample;
   assign rsp_mic_sample      = head.mic_sample;
   assign rsp_control_address = head.control_address;
   assign rsp_control_word    = head.control_word;
   assign rsp_status_bits     = head.status_bits;
   assign rsp_sample_count    = head.sample_count;
   assign rsp_sync_ok         = head.sync_ok;
   assign rsp_last            = head.last;

endmodule

// ===== test/deframe_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deframe_checker
// Watches the byte, result and register ports of the receive frame deframer.
// Keeps its own copy of the parser state and the registers, works out the
// results that each accepted byte should give and compares every accepted
// result field by field against the oldest one still due.
// ---------------------------------------------------------------------------
module deframe_checker #(
   parameter int PAYLOAD_BYTES = 504,
   parameter int MAX_RECEIVERS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_frame_start,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [1:0]                      rsp_kind,
   input  logic [1:0]                      rsp_receiver,
   input  logic signed [23:0]              rsp_i_sample,
   input  logic signed [23:0]              rsp_q_sample,
   input  logic signed [15:0]              rsp_mic_sample,
   input  logic [4:0]                      rsp_control_address,
   input  logic [31:0]                     rsp_control_word,
   input  logic [2:0]                      rsp_status_bits,
   input  logic [5:0]                      rsp_sample_count,
   input  logic                            rsp_sync_ok,
   input  logic                            rsp_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rfd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rfd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                            csr_pready,
   output int                              failures,
   output int                              waiting
);
   import rfd_pkg::*;

   localparam int         LAST_POS  = HEADER_BYTES + PAYLOAD_BYTES - 1;
   localparam logic [2:0] GP_MIC_LO = GP_MIC_HI + 3'd1;

   // register copies
   logic [2:0]  receivers_cfg;
   logic [18:0] threshold_cfg;
   logic [18:0] mic_step_cfg;

   // parser state
   logic [8:0]  frame_pos;
   logic        sync_held;
   logic [7:0]  command;
   logic [31:0] control_bits;
   logic [2:0]  slot;
   logic [1:0]  lane;
   logic [8:0]  payload_room;
   logic [23:0] i_latch;
   logic [23:0] sample_bits;
   logic [7:0]  mic_upper;
   logic [19:0] mic_level;
   logic [5:0]  groups_done;

   // results still due on the output, oldest first
   result_type  due_results[$];
   // newest result of the current byte, held back until its last flag is known
   result_type  held;
   logic        holding;

   function automatic void open_frame();
      frame_pos    = '0;
      sync_held    = 1'b1;
      slot         = '0;
      lane         = '0;
      payload_room = 9'(PAYLOAD_BYTES);
      groups_done  = '0;
   endfunction

   function automatic void queue_result(input result_type r);
      if (holding)
         due_results.push_back(held);
      held    = r;
      holding = 1'b1;
   endfunction

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   // one byte through the parser: header, sample groups and frame end
   task automatic deframe_byte(input logic [7:0] value, input logic start);
      int unsigned pos;
      int unsigned lanes;
      result_type  r;
      if (start)
         open_frame();
      pos = frame_pos;

      if (pos < SYNC_LEN) begin
         if (value != SYNC_BYTE)
            sync_held = 1'b0;
      end else if (pos == COMMAND_POS) begin
         command = value;
      end else if (pos < HEADER_BYTES) begin
         control_bits = {control_bits[23:0], value};
         if (pos == HEADER_BYTES - 1 && sync_held) begin
            r                 = '0;
            r.kind            = KIND_CONTROL;
            r.control_address = command[7:3];
            r.control_word    = control_bits;
            r.status_bits     = command[2:0];
            queue_result(r);
         end
      end else if (sync_held && payload_room != 0) begin
         // zero receivers still parse one receiver slot per group
         if (receivers_cfg == 3'd0)
            lanes = 1;
         else if (receivers_cfg > MAX_RECEIVERS)
            lanes = MAX_RECEIVERS;
         else
            lanes = receivers_cfg;

         if (slot == '0 && lane == '0 &&
             payload_room < BYTES_PER_RECEIVER * lanes + MIC_BYTES) begin
            // no room for a whole group: rest of the payload is ignored
            payload_room = '0;
         end else begin
            payload_room = payload_room - 9'd1;
            if (slot <= GP_Q_LAST) begin
               sample_bits = {sample_bits[15:0], value};
               if (slot == GP_I_LAST)
                  i_latch = sample_bits;
               if (slot == GP_Q_LAST) begin
                  if (receivers_cfg != 3'd0) begin
                     r          = '0;
                     r.kind     = KIND_IQ;
                     r.receiver = lane;
                     r.i_sample = i_latch;
                     r.q_sample = sample_bits;
                     queue_result(r);
                  end
                  if (lane + 1 < lanes) begin
                     lane = lane + 2'd1;
                     slot = '0;
                  end else begin
                     slot = GP_MIC_HI;
                  end
               end else begin
                  slot = slot + 3'd1;
               end
            end else if (slot == GP_MIC_HI) begin
               mic_upper = value;
               slot      = GP_MIC_LO;
            end else begin
               // decimator: emit the mic sample once the level reaches the threshold
               mic_level = mic_level + 20'(mic_step_cfg);
               if (mic_level >= threshold_cfg) begin
                  mic_level    = '0;
                  r            = '0;
                  r.kind       = KIND_MIC;
                  r.mic_sample = {mic_upper, value};
                  queue_result(r);
               end
               slot        = '0;
               lane        = '0;
               groups_done = groups_done + 6'd1;
            end
         end
      end

      // frame end on the last byte of the frame
      if (pos >= LAST_POS) begin
         r              = '0;
         r.kind         = KIND_FRAME_END;
         r.sample_count = sync_held ? groups_done : 6'd0;
         r.sync_ok      = sync_held;
         queue_result(r);
         open_frame();
      end else begin
         frame_pos = 9'(pos + 1);
      end

      if (holding) begin
         held.last = 1'b1;
         due_results.push_back(held);
         holding = 1'b0;
      end
   endtask

   // register writes, byte transactions and result transactions at each edge
   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         receivers_cfg = ACTIVE_RECEIVERS_RESET;
         threshold_cfg = RECEIVER_RATE_RESET;
         mic_step_cfg  = MIC_INCREMENT_RESET;
         open_frame();
         command      = '0;
         control_bits = '0;
         i_latch      = '0;
         sample_bits  = '0;
         mic_upper    = '0;
         mic_level    = '0;
         holding      = 1'b0;
         due_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
               REG_ACTIVE_RECEIVERS: receivers_cfg = csr_pwdata[2:0];
               REG_RECEIVER_RATE:    threshold_cfg = csr_pwdata[18:0];
               REG_MIC_INCREMENT:    mic_step_cfg  = csr_pwdata[18:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready)
            deframe_byte(req_data_byte, req_frame_start);

         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("result of kind %0d arrived with nothing due", rsp_kind);
               failures++;
            end else begin
               want = due_results.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("receiver", want.receiver, rsp_receiver);
               check_field("i_sample", $signed(want.i_sample), $signed(rsp_i_sample));
               check_field("q_sample", $signed(want.q_sample), $signed(rsp_q_sample));
               check_field("mic_sample", $signed(want.mic_sample),
                           $signed(rsp_mic_sample));
               check_field("control_address", want.control_address, rsp_control_address);
               check_field("control_word", want.control_word, rsp_control_word);
               check_field("status_bits", want.status_bits, rsp_status_bits);
               check_field("sample_count", want.sample_count, rsp_sample_count);
               check_field("sync_ok", want.sync_ok, rsp_sync_ok);
               check_field("last", want.last, rsp_last);
            end
         end
      end
      waiting = due_results.size();
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives the receive frame deframer with a short run of edge-value bytes,
// one whole frame and then a run of shortened frames under a range of
// register settings: clean frames, frames without a start flag, broken sync,
// cut-off frames and noise, with receiver count changes in mid-frame and
// random gaps on both channels.
// Checking is left to the deframe_checker instance.
// ---------------------------------------------------------------------------
module tb;
   import rfd_pkg::*;

   localparam int PAYLOAD_BYTES   = 504;
   localparam int MAX_RECEIVERS   = 4;
   localparam int FRAME_BYTES     = HEADER_BYTES + PAYLOAD_BYTES;
   localparam int RANDOM_FRAMES   = 10;
   localparam int CALM_FRAMES     = 2;
   // longest frame sent after the first whole one
   localparam int SHORT_FRAME_MAX = 48;

   // command byte 0xFF (address 31, status 7) followed by the control word
   localparam logic [39:0] EXTREME_CONTROL = 40'hFF_FF00A55A;
   // most negative I, most positive Q, most negative mic
   localparam logic [63:0] EXTREME_GROUP   = 64'h800000_7FFFFF_8000;

   typedef enum {
      FRAME_GOOD,
      FRAME_NO_START,
      FRAME_BAD_SYNC,
      FRAME_CUT,
      FRAME_NOISE
   } frame_shape_type;

   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_data_byte   = '0;
   logic                   req_frame_start = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready       = 1'b0;
   logic [1:0]             rsp_kind;
   logic [1:0]             rsp_receiver;
   logic signed [23:0]     rsp_i_sample;
   logic signed [23:0]     rsp_q_sample;
   logic signed [15:0]     rsp_mic_sample;
   logic [4:0]             rsp_control_address;
   logic [31:0]            rsp_control_word;
   logic [2:0]             rsp_status_bits;
   logic [5:0]             rsp_sample_count;
   logic                   rsp_sync_ok;
   logic                   rsp_last;
   logic                   csr_psel        = 1'b0;
   logic                   csr_penable     = 1'b0;
   logic                   csr_pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr       = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata      = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int   failures;
   int   waiting;
   // 0 means no idling, otherwise one chance in idle_odds per cycle
   int   idle_odds = 0;
   // set when the block sits at byte 0 of a frame
   logic aligned   = 1'b0;

   radio_frame_deframer #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .MAX_RECEIVERS (MAX_RECEIVERS)
   ) uut (.*);

   deframe_checker #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .MAX_RECEIVERS (MAX_RECEIVERS)
   ) watcher (.*);

   always #10 clock = ~clock;

   // one byte transaction, with a random gap in front of it
   task automatic send_byte(input logic [7:0] value, input logic start);
      @(negedge clock);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= value;
      req_frame_start <= start;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and let every due result come out
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (waiting != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // register write: setup cycle, then access cycle
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic configure(input logic [2:0] receivers, input logic [18:0] threshold,
                            input logic [18:0] mic_step);
      quiesce();
      csr_write(REG_ACTIVE_RECEIVERS, 32'(receivers));
      csr_write(REG_RECEIVER_RATE, 32'(threshold));
      csr_write(REG_MIC_INCREMENT, 32'(mic_step));
   endtask

   // one frame of the given shape, random header and payload content,
   // cut to at most max_length bytes
   task automatic drive_frame(input frame_shape_type shape, input int max_length);
      logic [7:0] frame_bytes [FRAME_BYTES];
      int         length;
      int         retune_at;
      int         bad_pos;
      logic       first_flag;
      logic       flag;
      length = FRAME_BYTES;
      if (shape == FRAME_CUT || shape == FRAME_NOISE)
         length = $urandom_range(1, FRAME_BYTES - 1);
      if (length > max_length)
         length = $urandom_range(1, max_length);
      for (int i = 0; i < FRAME_BYTES; i++)
         frame_bytes[i] = (i < SYNC_LEN && shape != FRAME_NOISE) ? SYNC_BYTE : 8'($urandom);
      if (shape == FRAME_BAD_SYNC) begin
         bad_pos = $urandom_range(0, SYNC_LEN - 1);
         frame_bytes[bad_pos] = frame_bytes[bad_pos] ^ (8'd1 << $urandom_range(0, 7));
      end
      // a missing start flag only makes sense right after a complete frame
      first_flag = !(shape == FRAME_NO_START && aligned);
      retune_at  = ($urandom_range(0, 2) == 0) ? $urandom_range(HEADER_BYTES, length) : -1;

      for (int i = 0; i < length; i++) begin
         if (i == retune_at) begin
            // receiver count changes under a running frame, usually mid-group
            quiesce();
            csr_write(REG_ACTIVE_RECEIVERS, 32'($urandom_range(0, 7)));
         end
         flag = (i == 0) ? first_flag : (shape == FRAME_NOISE && $urandom_range(0, 99) == 0);
         send_byte(frame_bytes[i], flag);
      end
      aligned = (length == FRAME_BYTES);
   endtask

   // result side: bursts of back-pressure
   initial begin : result_sink
      forever begin
         @(negedge clock);
         if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin : stimulus
      frame_shape_type shape;
      int              pick;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // opening run: one receiver, mic on every group
      idle_odds = 3;
      configure(3'd1, 19'd0, 19'd1);
      // broken sync, then a restart in mid-frame
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      for (int i = 0; i < SYNC_LEN; i++)
         send_byte(SYNC_BYTE, i == 0);
      for (int i = 4; i >= 0; i--)
         send_byte(EXTREME_CONTROL[8*i +: 8], 1'b0);
      for (int i = 7; i >= 0; i--)
         send_byte(EXTREME_GROUP[8*i +: 8], 1'b0);
      // another restart with an all-zero command and control word
      for (int i = 0; i < HEADER_BYTES; i++)
         send_byte(i < SYNC_LEN ? SYNC_BYTE : 8'h00, i == 0);

      // one whole frame, then short ones; settings from the extremes first
      for (int k = 0; k < RANDOM_FRAMES; k++) begin
         if (k >= RANDOM_FRAMES - CALM_FRAMES)
            idle_odds = 0;
         else
            idle_odds = 3 * $urandom_range(0, 2);

         case (k)
            0:       configure(3'd7, 19'd0, 19'd1);
            1:       configure(3'd1, 19'h7FFFF, 19'h7FFFF);
            2:       configure(3'd0, 19'h7FFFF, 19'd1);
            3:       configure(3'd4, RECEIVER_RATE_RESET, MIC_INCREMENT_RESET);
            default: configure(3'($urandom_range(0, 7)), 19'($urandom_range(0, 400000)),
                               19'($urandom_range(1, 200000)));
         endcase

         case (k)
            0, 2:    shape = FRAME_GOOD;
            1:       shape = FRAME_NO_START;
            3:       shape = FRAME_CUT;
            4:       shape = FRAME_BAD_SYNC;
            default: begin
               pick = $urandom_range(0, 9);
               if (k >= RANDOM_FRAMES - CALM_FRAMES || pick < 6)
                  shape = FRAME_GOOD;
               else if (pick == 6)
                  shape = FRAME_NO_START;
               else if (pick == 7)
                  shape = FRAME_BAD_SYNC;
               else if (pick == 8)
                  shape = FRAME_CUT;
               else
                  shape = FRAME_NOISE;
            end
         endcase
         drive_frame(shape, (k == 0) ? FRAME_BYTES : SHORT_FRAME_MAX);
      end

      // let the result side empty
      @(negedge clock);
      req_valid <= 1'b0;
      for (int n = 0; n < 5000 && waiting != 0; n++)
         @(negedge clock);
      if (waiting != 0) begin
         $error("%0d expected results never arrived", waiting);
         $display("radio_frame_deframer test failed");
      end else begin
         repeat (4) @(negedge clock);
         if (failures == 0)
            $display("radio_frame_deframer test passed");
         else
            $display("radio_frame_deframer test failed");
      end
      $finish;
   end

   // hard stop if the handshakes hang
   initial begin : watchdog
      #10ms;
      $error("run timed out");
      $display("radio_frame_deframer test failed");
      $finish;
   end

endmodule

// ===== radio_frame_deframer.f =====
+incdir+src
src/rfd_pkg.sv
src/rfd_csr.sv
src/rfd_parser.sv
src/rfd_result_queue.sv
src/radio_frame_deframer.sv
test/deframe_checker.sv
test/tb.sv
